FILE: sv/iee_pkg.sv
package iee_pkg;

  // Operator codes held on the operator stack
  localparam logic [2:0] OPC_OPEN = 3'd0;
  localparam logic [2:0] OPC_ADD  = 3'd1;
  localparam logic [2:0] OPC_SUB  = 3'd2;
  localparam logic [2:0] OPC_MUL  = 3'd3;
  localparam logic [2:0] OPC_DIV  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Characters
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Datapath operations
  localparam logic [3:0] DP_NOP      = 4'd0;
  localparam logic [3:0] DP_ACCUM    = 4'd1;  // accumulate digit
  localparam logic [3:0] DP_FLUSH    = 4'd2;  // push number, clear accumulator
  localparam logic [3:0] DP_PUSH_OP  = 4'd3;  // push operator code
  localparam logic [3:0] DP_POP_OP   = 4'd4;  // drop top operator
  localparam logic [3:0] DP_RED_RD   = 4'd5;  // read top two values
  localparam logic [3:0] DP_RED_EX   = 4'd6;  // start arithmetic
  localparam logic [3:0] DP_RED_WB   = 4'd7;  // write result back
  localparam logic [3:0] DP_CLEAR    = 4'd8;  // clear stacks and number
  localparam logic [3:0] DP_FAIL     = 4'd9;  // record error, clear
  localparam logic [3:0] DP_RES_RD   = 4'd10; // read bottom value for result

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] opc;    // operator code for a push
    logic [3:0] digit;  // digit for accumulate
    logic [1:0] err;    // error for fail
  } iee_cmd_t;

  typedef struct packed {
    logic       in_number;
    logic       err_set;
    logic [1:0] err;
    logic       op_empty;
    logic       op_full;
    logic       val_full;
    logic       val_lt2;
    logic       val_one;
    logic [2:0] op_top;
    logic       alu_busy;
    logic       alu_done;
    logic       div_zero;
  } iee_sts_t;

  function automatic logic [1:0] rank(input logic [2:0] code);
    case (code)
      OPC_ADD, OPC_SUB: rank = 2'd1;
      OPC_MUL, OPC_DIV: rank = 2'd2;
      default:          rank = 2'd0;
    endcase
  endfunction

endpackage

FILE: sv/iee_alu.sv
module iee_alu import iee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  opc_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] res_o
);

  // Multiply in three 32x32 partial products, divide one bit a cycle
  logic        busy_q, busy_d;
  logic        is_div_q, is_div_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] a_q, a_d, b_q, b_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] rem_q, rem_d;
  logic        neg_q, neg_d;
  logic        done_q, done_d;
  logic [63:0] res_q, res_d;
  logic [64:0] rem_sh;
  logic [63:0] pp;

  always_comb begin
    busy_d = busy_q; is_div_d = is_div_q; cnt_d = cnt_q;
    a_d = a_q; b_d = b_q; acc_d = acc_q; rem_d = rem_q; neg_d = neg_q;
    done_d = 1'b0; res_d = res_q;
    rem_sh = '0; pp = '0;
    if (start_i) begin
      done_d = 1'b0;
      case (opc_i)
        OPC_ADD: begin res_d = a_i + b_i; done_d = 1'b1; end
        OPC_SUB: begin res_d = a_i - b_i; done_d = 1'b1; end
        OPC_MUL: begin
          busy_d = 1'b1; is_div_d = 1'b0; cnt_d = '0;
          a_d = a_i; b_d = b_i; acc_d = '0;
        end
        default: begin
          busy_d = 1'b1; is_div_d = 1'b1; cnt_d = '0;
          a_d = a_i[63] ? 64'd0 - a_i : a_i;
          b_d = b_i[63] ? 64'd0 - b_i : b_i;
          neg_d = a_i[63] ^ b_i[63];
          rem_d = '0;
        end
      endcase
    end else if (busy_q) begin
      if (!is_div_q) begin
        // Step through low*low, low*high, high*low terms
        case (cnt_q[1:0])
          2'd0: pp = a_q[31:0] * b_q[31:0];
          2'd1: pp = {a_q[31:0] * b_q[63:32], 32'd0};
          default: pp = {a_q[63:32] * b_q[31:0], 32'd0};
        endcase
        acc_d = acc_q + pp;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd2) begin
          busy_d = 1'b0; done_d = 1'b1; res_d = acc_q + pp;
        end
      end else begin
        // Restoring division, quotient bits shift into a_q
        rem_sh = {rem_q, a_q[63]};
        if (rem_sh >= {1'b0, b_q}) begin
          rem_d = rem_sh[63:0] - b_q;
          a_d = {a_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh[63:0];
          a_d = {a_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_d = 1'b0; done_d = 1'b1;
          res_d = neg_q ? 64'd0 - a_d : a_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d;
    a_q <= a_d; b_q <= b_d; acc_q <= acc_d; rem_q <= rem_d;
    neg_q <= neg_d; res_q <= res_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: sv/iee_datapath.sv
module iee_datapath import iee_pkg::*; #(
  parameter int VALUE_DEPTH    = 32,
  parameter int OPERATOR_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  iee_cmd_t    cmd_i,
  output iee_sts_t    sts_o,
  output logic [63:0] value_o,
  output logic [1:0]  status_o
);

  localparam int VW = $clog2(VALUE_DEPTH);
  localparam int OW = $clog2(OPERATOR_DEPTH);

  // Stack memories, registered reads
  logic [63:0] vmem [VALUE_DEPTH];
  logic [2:0]  omem [OPERATOR_DEPTH];

  logic [VW:0] vcnt_q, vcnt_d;
  logic [OW:0] ocnt_q, ocnt_d;
  logic [63:0] acc_q, acc_d;
  logic        innum_q, innum_d;
  logic [1:0]  err_q, err_d;
  logic [2:0]  otop_q, otop_d;
  logic [63:0] ra_q, rb_q;
  logic [2:0]  rop_q;

  logic        vwe;
  logic [VW-1:0] vwa;
  logic [63:0] vwd;
  logic        alu_start, alu_busy, alu_done;
  logic [63:0] alu_res;

  iee_alu u_alu (
    .clk_i, .rst_ni,
    .start_i(alu_start), .opc_i(rop_q), .a_i(ra_q), .b_i(rb_q),
    .busy_o(alu_busy), .done_o(alu_done), .res_o(alu_res)
  );

  always_comb begin
    vcnt_d = vcnt_q; ocnt_d = ocnt_q; acc_d = acc_q; innum_d = innum_q;
    err_d = err_q; otop_d = otop_q;
    vwe = 1'b0; vwa = '0; vwd = acc_q; alu_start = 1'b0;
    case (cmd_i.op)
      DP_ACCUM: begin
        acc_d = (acc_q << 3) + (acc_q << 1) + {60'd0, cmd_i.digit};
        innum_d = 1'b1;
      end
      DP_FLUSH: begin
        vwe = 1'b1; vwa = vcnt_q[VW-1:0]; vwd = acc_q;
        vcnt_d = vcnt_q + 1'b1; acc_d = '0; innum_d = 1'b0;
      end
      DP_PUSH_OP: begin
        ocnt_d = ocnt_q + 1'b1; otop_d = cmd_i.opc;
      end
      DP_POP_OP: ocnt_d = ocnt_q - 1'b1;
      DP_RED_RD: begin
        ocnt_d = ocnt_q - 1'b1;
        vcnt_d = vcnt_q - 2'd2;
      end
      DP_RED_EX: alu_start = 1'b1;
      DP_RED_WB: begin
        vwe = 1'b1; vwa = vcnt_q[VW-1:0]; vwd = alu_res;
        vcnt_d = vcnt_q + 1'b1;
      end
      DP_CLEAR: begin
        vcnt_d = '0; ocnt_d = '0; acc_d = '0; innum_d = 1'b0; err_d = ST_OK;
      end
      DP_FAIL: begin
        vcnt_d = '0; ocnt_d = '0; acc_d = '0; innum_d = 1'b0;
        if (err_q == ST_OK) err_d = cmd_i.err;
      end
      default: ;
    endcase
  end

  // Operator top is re-read after a pop
  logic [OW-1:0] ord_a;
  logic          orefresh;
  assign orefresh = (cmd_i.op == DP_POP_OP) || (cmd_i.op == DP_RED_RD);
  assign ord_a = ocnt_q[OW-1:0] - 2'd2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_PUSH_OP) omem[ocnt_q[OW-1:0]] <= cmd_i.opc;
    if (orefresh) begin
      otop_q <= omem[ord_a];
    end else begin
      otop_q <= otop_d;
    end
    if (cmd_i.op == DP_RED_RD) rop_q <= otop_q;
  end

  logic [VW-1:0] vra_a, vra_b;
  assign vra_b = vcnt_q[VW-1:0] - 1'b1;
  assign vra_a = (cmd_i.op == DP_RES_RD) ? '0 : vcnt_q[VW-1:0] - 2'd2;

  // Load operands or the result, hold them otherwise
  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vwa] <= vwd;
    if (cmd_i.op == DP_RED_RD || cmd_i.op == DP_RES_RD) ra_q <= vmem[vra_a];
    if (cmd_i.op == DP_RED_RD) rb_q <= vmem[vra_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0; ocnt_q <= '0; acc_q <= '0; innum_q <= 1'b0; err_q <= ST_OK;
    end else begin
      vcnt_q <= vcnt_d; ocnt_q <= ocnt_d; acc_q <= acc_d;
      innum_q <= innum_d; err_q <= err_d;
    end
  end

  always_comb begin
    sts_o.in_number = innum_q;
    sts_o.err_set   = err_q != ST_OK;
    sts_o.err       = err_q;
    sts_o.op_empty  = ocnt_q == '0;
    sts_o.op_full   = ocnt_q >= (OW+1)'(OPERATOR_DEPTH);
    sts_o.val_full  = vcnt_q >= (VW+1)'(VALUE_DEPTH);
    sts_o.val_lt2   = vcnt_q < (VW+1)'(2);
    sts_o.val_one   = vcnt_q == (VW+1)'(1);
    sts_o.op_top    = otop_q;
    sts_o.alu_busy  = alu_busy;
    sts_o.alu_done  = alu_done;
    sts_o.div_zero  = (rop_q == OPC_DIV) && (rb_q == '0);
  end

  assign value_o  = ra_q;
  assign status_o = err_q;

endmodule

FILE: sv/iee_ctrl.sv
module iee_ctrl import iee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  input  logic       last_i,
  output logic       res_load_o,
  input  logic       out_free_i,
  output iee_cmd_t   cmd_o,
  input  iee_sts_t   sts_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;  // classify held character
  localparam logic [3:0] S_LOOP  = 4'd2;  // reduce loop for operator, ')' or end
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_WAIT  = 4'd5;
  localparam logic [3:0] S_END   = 4'd6;  // final reduction
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_SETTLE = 4'd10;

  localparam logic [1:0] M_OPER  = 2'd0;
  localparam logic [1:0] M_CLOSE = 2'd1;
  localparam logic [1:0] M_END   = 2'd2;

  logic [3:0] st_q, st_d;
  logic [7:0] ch_q;
  logic       last_q;
  logic [1:0] mode_q, mode_d;
  logic [2:0] code_q, code_d;
  logic       flushed_q, flushed_d;
  logic       is_digit, is_oper;
  logic [2:0] ccode;

  assign in_ready_o = st_q == S_IDLE;
  assign is_digit = ch_q >= CH_ZERO && ch_q <= CH_NINE;

  always_comb begin
    is_oper = 1'b1;
    case (ch_q)
      CH_ADD:  ccode = OPC_ADD;
      CH_SUB:  ccode = OPC_SUB;
      CH_MUL:  ccode = OPC_MUL;
      CH_DIV:  ccode = OPC_DIV;
      default: begin ccode = OPC_OPEN; is_oper = 1'b0; end
    endcase
  end

  always_comb begin
    st_d = st_q; mode_d = mode_q; code_d = code_q; flushed_d = flushed_q;
    cmd_o = '0; res_load_o = 1'b0;
    case (st_q)
      S_IDLE: if (in_valid_i) begin st_d = S_DISP; flushed_d = 1'b0; end
      S_DISP: begin
        if (sts_i.err_set) begin
          st_d = last_q ? S_CHK : S_IDLE;
        end else if (is_digit) begin
          cmd_o.op = DP_ACCUM; cmd_o.digit = 4'(ch_q - CH_ZERO);
          st_d = last_q ? S_SETTLE : S_IDLE;
        end else if (sts_i.in_number && !flushed_q) begin
          flushed_d = 1'b1;
          if (sts_i.val_full) begin
            cmd_o.op = DP_FAIL; cmd_o.err = ST_OVERFLOW;
          end else cmd_o.op = DP_FLUSH;
        end else if (ch_q == CH_OPEN) begin
          if (sts_i.op_full) begin cmd_o.op = DP_FAIL; cmd_o.err = ST_OVERFLOW; end
          else begin cmd_o.op = DP_PUSH_OP; cmd_o.opc = OPC_OPEN; end
          st_d = last_q ? S_SETTLE : S_IDLE;
        end else if (ch_q == CH_CLOSE) begin
          mode_d = M_CLOSE; st_d = S_LOOP;
        end else if (is_oper) begin
          mode_d = M_OPER; code_d = ccode; st_d = S_LOOP;
        end else begin
          cmd_o.op = DP_FAIL; cmd_o.err = ST_MALFORMED;
          st_d = last_q ? S_SETTLE : S_IDLE;
        end
      end
      S_SETTLE: st_d = S_END;
      S_LOOP: begin
        if (sts_i.err_set) st_d = (mode_q == M_END || last_q) ? S_CHK : S_IDLE;
        else if (sts_i.op_empty) begin
          if (mode_q == M_OPER) begin
            cmd_o.op = DP_PUSH_OP; cmd_o.opc = code_q;
          end
          st_d = (mode_q == M_END) ? S_CHK : (last_q ? S_SETTLE : S_IDLE);
        end else if (sts_i.op_top == OPC_OPEN && mode_q != M_OPER) begin
          cmd_o.op = DP_POP_OP;
          if (mode_q == M_CLOSE) st_d = last_q ? S_SETTLE : S_IDLE;
          else st_d = S_SETTLE;
        end else if (mode_q == M_OPER && rank(sts_i.op_top) < rank(code_q)) begin
          if (sts_i.op_full) begin cmd_o.op = DP_FAIL; cmd_o.err = ST_OVERFLOW; end
          else begin cmd_o.op = DP_PUSH_OP; cmd_o.opc = code_q; end
          st_d = last_q ? S_SETTLE : S_IDLE;
        end else if (sts_i.val_lt2) begin
          cmd_o.op = DP_FAIL; cmd_o.err = ST_MALFORMED;
          st_d = S_LOOP;
        end else begin
          cmd_o.op = DP_RED_RD; st_d = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.div_zero) begin
          cmd_o.op = DP_FAIL; cmd_o.err = ST_DIV_ZERO; st_d = S_LOOP;
        end else begin
          cmd_o.op = DP_RED_EX; st_d = S_WAIT;
        end
      end
      S_WAIT: if (sts_i.alu_done) begin
        cmd_o.op = DP_RED_WB; st_d = S_LOOP;
      end
      S_END: begin
        if (!sts_i.err_set && sts_i.in_number) begin
          if (sts_i.val_full) begin cmd_o.op = DP_FAIL; cmd_o.err = ST_OVERFLOW; end
          else cmd_o.op = DP_FLUSH;
        end
        mode_d = M_END; st_d = S_LOOP;
      end
      S_CHK: begin
        if (!sts_i.err_set && !sts_i.val_one) begin
          cmd_o.op = DP_FAIL; cmd_o.err = ST_MALFORMED;
        end
        st_d = S_RES;
      end
      S_RES: begin cmd_o.op = DP_RES_RD; st_d = S_EMIT; end
      S_EMIT: if (out_free_i) begin
        res_load_o = 1'b1; cmd_o.op = DP_CLEAR; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; mode_q <= M_OPER; flushed_q <= 1'b0;
    end else begin
      st_q <= st_d;
      mode_q <= mode_d; flushed_q <= flushed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    if (st_q == S_IDLE && in_valid_i) begin
      ch_q <= character_i; last_q <= last_i;
    end
  end

endmodule

FILE: sv/infix_expression_evaluator.sv
// Infix expression evaluator.
// Input channel: one ASCII character per item (character_i, last_i) with
// in_valid_i/in_ready_o. Digits accumulate into a number; + - * / ( ) drive
// a value stack and an operator stack held in memories.
// Output channel: one item (value_o, status_o) per expression, produced only
// after the item with last_i set, with out_valid_o/out_ready_i.
// A character that ends a number first pushes that number; an operator or ')'
// then reduces the operator stack, each reduction reading two values, running
// the ALU (three-step 32x32 multiply for *, one quotient bit a cycle for /)
// and writing the result back. The last item adds the final reductions and
// pops every unmatched '('. Items are taken one at a time.
// Reset clears both stack counts, the number and the status; the stack
// contents are not cleared. When the receiver stalls, the result holds in
// the output register; the next expression is accepted and worked on until
// its own result must be loaded.
module infix_expression_evaluator import iee_pkg::*; #(
  parameter int VALUE_DEPTH    = 32,
  parameter int OPERATOR_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic [1:0]  status_o
);

  iee_cmd_t    cmd;
  iee_sts_t    sts;
  logic        res_load;
  logic [63:0] dp_value;
  logic [1:0]  dp_status;
  logic        ovalid_q;
  logic [63:0] value_q;
  logic [1:0]  status_q;

  iee_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .character_i, .last_i,
    .res_load_o(res_load), .out_free_i(!ovalid_q || out_ready_i),
    .cmd_o(cmd), .sts_i(sts)
  );

  iee_datapath #(.VALUE_DEPTH(VALUE_DEPTH), .OPERATOR_DEPTH(OPERATOR_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .value_o(dp_value), .status_o(dp_status)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (res_load) ovalid_q <= 1'b1;
    else if (out_ready_i) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q <= dp_status;
      value_q  <= (dp_status == ST_OK) ? dp_value : '0;
    end
  end

  assign out_valid_o = ovalid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

FILE: tb/testbench.sv
module testbench import iee_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VDEPTH = 32;
  localparam int ODEPTH = 32;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  character_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] value_o;
  logic [1:0]  status_o;

  infix_expression_evaluator #(.VALUE_DEPTH(VDEPTH), .OPERATOR_DEPTH(ODEPTH)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .character_i, .last_i,
    .out_valid_o, .out_ready_i, .value_o, .status_o
  );

  typedef struct {
    logic [63:0] value;
    logic [1:0]  status;
  } eval_result_t;

  // Directed row: character, last, and an optional typed-in result
  typedef struct {
    logic [7:0]  ch;
    logic        last;
    logic        known;
    logic [63:0] value;
    logic [1:0]  status;
  } stim_row_t;

  // Predictor state
  logic [63:0] vals [VDEPTH];
  int          vcnt;
  logic [2:0]  ops [ODEPTH];
  int          ocnt;
  logic [63:0] accum;
  logic        in_num;
  logic [1:0]  err;

  eval_result_t pending_results[$];
  int           mismatches = 0;
  bit           tx_idle_on;
  bit           rx_idle_on;

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void clear_work();
    vcnt = 0;
    ocnt = 0;
    accum = '0;
    in_num = 1'b0;
  endfunction

  function automatic void raise_error(logic [1:0] code);
    if (err == ST_OK) err = code;
    clear_work();
  endfunction

  function automatic void push_val(logic [63:0] v);
    if (err != ST_OK) return;
    if (vcnt >= VDEPTH) begin
      raise_error(ST_OVERFLOW);
      return;
    end
    vals[vcnt] = v;
    vcnt++;
  endfunction

  function automatic void push_op(logic [2:0] code);
    if (err != ST_OK) return;
    if (ocnt >= ODEPTH) begin
      raise_error(ST_OVERFLOW);
      return;
    end
    ops[ocnt] = code;
    ocnt++;
  endfunction

  function automatic int op_rank(logic [2:0] code);
    if (code == OPC_ADD || code == OPC_SUB) return 1;
    if (code == OPC_MUL || code == OPC_DIV) return 2;
    return 0;
  endfunction

  // Apply the top operator to the top two values
  function automatic void apply_top();
    logic [63:0] a, b, r, ma, mb, q;
    logic [2:0]  op;
    if (err != ST_OK || ocnt == 0) return;
    if (vcnt < 2) begin
      raise_error(ST_MALFORMED);
      return;
    end
    ocnt--;
    op = ops[ocnt];
    b = vals[vcnt - 1];
    a = vals[vcnt - 2];
    vcnt -= 2;
    case (op)
      OPC_ADD: r = a + b;
      OPC_SUB: r = a - b;
      OPC_MUL: r = a * b;
      OPC_DIV: begin
        if (b == '0) begin
          raise_error(ST_DIV_ZERO);
          return;
        end
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        r = (a[63] ^ b[63]) ? -q : q;
      end
      default: begin
        raise_error(ST_MALFORMED);
        return;
      end
    endcase
    vals[vcnt] = r;
    vcnt++;
  endfunction

  function automatic void flush_num();
    if (in_num) begin
      in_num = 1'b0;
      push_val(accum);
      accum = '0;
    end
  endfunction

  function automatic void take_char(logic [7:0] c);
    logic [2:0] code;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      accum = accum * 64'd10 + 64'(c - CH_ZERO);
      in_num = 1'b1;
      return;
    end
    flush_num();
    if (err != ST_OK) return;
    if (c == CH_OPEN) begin
      push_op(OPC_OPEN);
      return;
    end
    if (c == CH_CLOSE) begin
      while (err == ST_OK && ocnt > 0 && ops[ocnt - 1] != OPC_OPEN) apply_top();
      if (err == ST_OK && ocnt > 0) ocnt--;
      return;
    end
    case (c)
      CH_ADD: code = OPC_ADD;
      CH_SUB: code = OPC_SUB;
      CH_MUL: code = OPC_MUL;
      CH_DIV: code = OPC_DIV;
      default: begin
        raise_error(ST_MALFORMED);
        return;
      end
    endcase
    while (err == ST_OK && ocnt > 0 && op_rank(ops[ocnt - 1]) >= op_rank(code)) apply_top();
    push_op(code);
  endfunction

  // Advance the predictor by one item; return 1 with the result on a last item
  function automatic bit evaluate_char(logic [7:0] c, logic lst, output eval_result_t res);
    res.value = '0;
    res.status = ST_OK;
    if (err == ST_OK) take_char(c);
    if (!lst) return 0;
    if (err == ST_OK) flush_num();
    while (err == ST_OK && ocnt > 0) begin
      if (ops[ocnt - 1] == OPC_OPEN) ocnt--;
      else apply_top();
    end
    if (err == ST_OK && vcnt != 1) raise_error(ST_MALFORMED);
    res.value = (err == ST_OK) ? vals[0] : 64'd0;
    res.status = err;
    clear_work();
    err = ST_OK;
    return 1;
  endfunction

  // Send one item, hold until accepted
  task automatic send_char(logic [7:0] c, logic lst);
    while (tx_idle_on && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    character_i <= c;
    last_i <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Predict, take a typed-in result where given, then send
  task automatic drive_char(logic [7:0] c, logic lst, logic known = 1'b0,
                            logic [63:0] kv = '0, logic [1:0] ks = ST_OK);
    eval_result_t res;
    if (evaluate_char(c, lst, res)) begin
      if (known) begin
        res.value = kv;
        res.status = ks;
      end
      pending_results.push_back(res);
    end
    send_char(c, lst);
  endtask

  task automatic drive_string(string s);
    for (int i = 0; i < s.len(); i++) drive_char(s[i], i == s.len() - 1);
  endtask

  // Random digit string of n characters
  function automatic string rand_number(int n);
    string s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rand_expr(int depth);
    string s;
    int terms;
    byte opch [4] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV};
    terms = $urandom_range(1, 4);
    s = "";
    for (int t = 0; t < terms; t++) begin
      if (t > 0) s = {s, string'(opch[$urandom_range(3)])};
      if (depth > 0 && $urandom_range(3) == 0)
        s = {s, "(", rand_expr(depth - 1), ")"};
      else if ($urandom_range(15) == 0)
        s = {s, rand_number($urandom_range(15, 22))};
      else
        s = {s, rand_number($urandom_range(1, 3))};
    end
    return s;
  endfunction

  // Receive side: random stall, compare against oldest prediction
  always @(posedge clk_i) begin
    eval_result_t exp_res;
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: value %h status %0d",
                                         value_o, status_o);
        end else begin
          exp_res = pending_results.pop_front();
          if (value_o !== exp_res.value || status_o !== exp_res.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                       exp_res.value, exp_res.status, value_o, status_o);
          end
        end
      end
      out_ready_i <= !(rx_idle_on && $urandom_range(99) < 10);
    end
  end

  // Run limit
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    string s;
    int sent;
    int n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    character_i = '0;
    last_i = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    clear_work();
    err = ST_OK;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: digit extremes, each operator, errors, parentheses
    rows = '{
      '{CH_ZERO, 1'b1, 1'b1, 64'd0, ST_OK},
      '{CH_NINE, 1'b1, 1'b1, 64'd9, ST_OK},
      '{8'h37, 1'b0, 1'b0, 64'd0, ST_OK},
      '{CH_ADD, 1'b0, 1'b0, 64'd0, ST_OK},
      '{8'h32, 1'b0, 1'b0, 64'd0, ST_OK},
      '{CH_MUL, 1'b0, 1'b0, 64'd0, ST_OK},
      '{8'h33, 1'b1, 1'b1, 64'd13, ST_OK},
      '{8'h35, 1'b0, 1'b0, 64'd0, ST_OK},
      '{CH_DIV, 1'b0, 1'b0, 64'd0, ST_OK},
      '{CH_ZERO, 1'b1, 1'b1, 64'd0, ST_DIV_ZERO},
      '{CH_SUB, 1'b1, 1'b1, 64'd0, ST_MALFORMED},
      '{8'h20, 1'b1, 1'b1, 64'd0, ST_MALFORMED},
      '{8'hFF, 1'b1, 1'b1, 64'd0, ST_MALFORMED},
      '{CH_OPEN, 1'b1, 1'b1, 64'd0, ST_MALFORMED},
      '{CH_CLOSE, 1'b1, 1'b1, 64'd0, ST_MALFORMED},
      '{CH_OPEN, 1'b0, 1'b0, 64'd0, ST_OK},
      '{8'h34, 1'b0, 1'b0, 64'd0, ST_OK},
      '{CH_SUB, 1'b0, 1'b0, 64'd0, ST_OK},
      '{8'h36, 1'b0, 1'b0, 64'd0, ST_OK},
      '{CH_CLOSE, 1'b0, 1'b0, 64'd0, ST_OK},
      '{CH_MUL, 1'b0, 1'b0, 64'd0, ST_OK},
      '{8'h33, 1'b1, 1'b0, 64'd0, ST_OK}
    };
    foreach (rows[i]) drive_char(rows[i].ch, rows[i].last, rows[i].known,
                                 rows[i].value, rows[i].status);
    // Wrapping number, most negative over minus one, open left over, (1)(2), stray ')'
    drive_string("99999999999999999999");
    drive_string("(0-9223372036854775807-1)/(0-1)");
    drive_string("(((5");
    drive_string("(1)(2)");
    drive_string("1)+2");
    // Overflow of the operator stack, then the value stack
    s = "";
    for (int i = 0; i < ODEPTH + 1; i++) s = {s, "("};
    drive_string({s, "1"});
    s = "";
    for (int i = 0; i < VDEPTH + 1; i++) s = {s, "(1)"};
    drive_string(s);

    // Hold off until every result is in
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    // Random part; a stretch with no idling in the middle
    sent = 0;
    while (sent < 930) begin
      tx_idle_on = !(sent > 400 && sent < 600);
      rx_idle_on = tx_idle_on;
      n = $urandom_range(99);
      if (n < 80) begin
        s = rand_expr(3);
      end else if (n < 92) begin
        // Broken: insert a random byte somewhere
        s = rand_expr(2);
        n = $urandom_range(s.len());
        s = {s.substr(0, n - 1), string'(8'($urandom_range(255))),
             s.substr(n, s.len() - 1)};
      end else begin
        s = "";
        for (int i = $urandom_range(1, 6); i > 0; i--)
          s = {s, string'(8'($urandom_range(255)))};
      end
      drive_string(s);
      sent += s.len();
    end
    tx_idle_on = 1'b1;
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: infix_expression_evaluator.f
sv/iee_pkg.sv
sv/iee_alu.sv
sv/iee_datapath.sv
sv/iee_ctrl.sv
sv/infix_expression_evaluator.sv
tb/testbench.sv
